[rtl/core/wwc_pkg.sv]
// ----------------------------------------------------------------------------
// Word combiner package
// Transfer types, descriptor codes and helper functions shared by the
// word-aligned hybrid bitmap word combiner.
// ----------------------------------------------------------------------------
package wwc_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] literal_word;
  } in_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        out_last;
  } out_t;

  // Descriptor codes; the held kind uses the same codes.
  localparam logic [1:0] FUNC_LIT  = 2'd0;
  localparam logic [1:0] FUNC_ZERO = 2'd1;
  localparam logic [1:0] FUNC_ONE  = 2'd2;
  localparam logic [1:0] FUNC_END  = 2'd3;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [31:0] ZERO_FILL_WORD = 32'h0000_0001;
  localparam logic [31:0] ONE_FILL_WORD  = 32'h4000_0001;

  localparam int unsigned LEN_LSB  = 27;
  localparam int unsigned PAIR_LSB = 23;
  localparam int unsigned TYPE_BIT = 30;
  localparam logic [5:0]  MAX_SPAN = 6'd21;

  function automatic logic [5:0] clz32(input logic [31:0] x);
    logic [31:0] v;
    logic [5:0]  n;
    v = x;
    n = '0;
    if (v[31:16] == '0) begin
      n[4] = 1'b1;
      v    = v << 16;
    end
    if (v[31:24] == '0) begin
      n[3] = 1'b1;
      v    = v << 8;
    end
    if (v[31:28] == '0) begin
      n[2] = 1'b1;
      v    = v << 4;
    end
    if (v[31:30] == '0) begin
      n[1] = 1'b1;
      v    = v << 2;
    end
    if (v[31] == 1'b0) begin
      n[0] = 1'b1;
    end
    if (x == '0) begin
      n = 6'd32;
    end
    return n;
  endfunction

  function automatic logic [5:0] ctz32(input logic [31:0] x);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = x[31-i];
    end
    return clz32(r);
  endfunction

  // Mask of the run counter field for a given span length field.
  function automatic logic [26:0] run_mask(input logic [2:0] len);
    logic [26:0] m;
    unique case (len)
      3'd0:    m = 27'h7FF_FFFF;
      3'd1:    m = 27'h00F_FFFF;
      3'd2:    m = 27'h001_FFFF;
      3'd3:    m = 27'h000_3FFF;
      3'd4:    m = 27'h000_07FF;
      3'd5:    m = 27'h000_00FF;
      3'd6:    m = 27'h000_001F;
      3'd7:    m = 27'h000_0003;
      default: m = 27'h7FF_FFFF;
    endcase
    return m;
  endfunction

endpackage

[rtl/core/wwc_in_reg.sv]
// ----------------------------------------------------------------------------
// Input register
// Captures one descriptor per transfer and holds it until the combining stage
// takes it.
// ----------------------------------------------------------------------------
module wwc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wwc_pkg::in_t  in_data_i,
  input  logic          take_i,
  output logic          valid_o,
  output wwc_pkg::in_t  data_o
);
  import wwc_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/core/wwc_fold.sv]
// ----------------------------------------------------------------------------
// Fill folding logic
// Trims a held literal and packs it with a fill type and a fresh run counter
// into one folded word, when its set bits span few enough groups.
// ----------------------------------------------------------------------------
module wwc_fold (
  input  logic [31:0] lit_word_i,
  input  logic        fill_one_i,
  output logic        fold_ok_o,
  output logic [31:0] fold_word_o
);
  import wwc_pkg::*;

  logic [31:0] body;
  logic [5:0]  lz;
  logic [5:0]  tz;
  logic [3:0]  pairs;
  logic [5:0]  span;
  logic [5:0]  span_rnd;
  logic [13:0] len_prod;
  logic [2:0]  len;
  logic [4:0]  len_x3;
  logic [4:0]  shl;
  logic [31:0] trimmed;
  logic [31:0] packed_bits;

  always_comb begin
    body     = {1'b0, lit_word_i[30:0]};
    lz       = clz32(body);
    tz       = ctz32(body);
    pairs    = tz[4:1];
    span     = 6'd32 - lz - {1'b0, pairs, 1'b0};
    span_rnd = span + 6'd2;
    // Division by three through a reciprocal, exact for these small values.
    len_prod = 14'(span_rnd) * 14'd171;
    len      = len_prod[11:9];
    len_x3   = {1'b0, len, 1'b0} + {2'b00, len};
    shl      = 5'd23 - len_x3;
    trimmed  = body >> {pairs, 1'b0};
    packed_bits = trimmed << shl;

    fold_ok_o   = (body != '0) && (span <= MAX_SPAN);
    fold_word_o = packed_bits;
    fold_word_o[LEN_LSB +: 3]  = len;
    fold_word_o[PAIR_LSB +: 4] = pairs;
    fold_word_o[TYPE_BIT]      = fill_one_i;
    fold_word_o[0]             = 1'b1;
  end

endmodule

[rtl/core/wwc_combine.sv]
// ----------------------------------------------------------------------------
// Combining stage
// Holds the newest compressed word and its kind, applies one descriptor per
// cycle while fire_i is high and reports the word that it displaces.
// ----------------------------------------------------------------------------
module wwc_combine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  wwc_pkg::in_t  item_i,
  output logic          emit_o,
  output wwc_pkg::out_t emit_data_o
);
  import wwc_pkg::*;

  logic [31:0] word_q, word_d;
  logic [1:0]  kind_q, kind_d;
  logic        fold_ok;
  logic [31:0] fold_word;
  logic        counter_full;
  logic        absorbed;

  wwc_fold u_fold (
    .lit_word_i  (word_q),
    .fill_one_i  (item_i.func == FUNC_ONE),
    .fold_ok_o   (fold_ok),
    .fold_word_o (fold_word)
  );

  assign counter_full =
    (word_q[26:0] & run_mask(word_q[LEN_LSB +: 3])) == run_mask(word_q[LEN_LSB +: 3]);

  always_comb begin
    word_d   = word_q;
    kind_d   = kind_q;
    absorbed = 1'b0;
    emit_o   = 1'b0;
    emit_data_o.out_word = word_q;
    emit_data_o.out_last = 1'b0;
    if (fire_i) begin
      unique case (item_i.func)
        FUNC_END: begin
          emit_o = (kind_q != KIND_NONE);
          emit_data_o.out_last = 1'b1;
          word_d = '0;
          kind_d = KIND_NONE;
        end
        FUNC_LIT: begin
          emit_o = (kind_q != KIND_NONE);
          word_d = item_i.literal_word;
          kind_d = FUNC_LIT;
        end
        default: begin
          if (kind_q == FUNC_LIT && fold_ok) begin
            absorbed = 1'b1;
            word_d   = fold_word;
          end else if (kind_q == item_i.func && !counter_full) begin
            absorbed = 1'b1;
            word_d   = word_q + 32'd1;
          end
          if (!absorbed) begin
            emit_o = (kind_q != KIND_NONE);
            word_d = (item_i.func == FUNC_ZERO) ? ZERO_FILL_WORD : ONE_FILL_WORD;
          end
          kind_d = item_i.func;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      kind_q <= KIND_NONE;
    end else begin
      word_q <= word_d;
      kind_q <= kind_d;
    end
  end

`ifndef SYNTHESIS
  // An empty holding register always carries a zero word.
  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kind_q == KIND_NONE |-> word_q == '0)
    else $error("held word not cleared while nothing is held");

  // A run counter never carries into the type or flag bits of a fill word.
  a_fill_type_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_q == FUNC_ZERO || kind_q == FUNC_ONE) |->
      (word_q[31] == 1'b0 && word_q[TYPE_BIT] == (kind_q == FUNC_ONE)))
    else $error("fill word type bit does not match held kind");

  // An end item always leaves the holding register empty.
  a_end_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.func == FUNC_END |=> kind_q == KIND_NONE)
    else $error("holding register not emptied by end item");
`endif

endmodule

[rtl/core/wwc_out_reg.sv]
// ----------------------------------------------------------------------------
// Output register
// Holds one finished word until the downstream transfer completes.
// ----------------------------------------------------------------------------
module wwc_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  wwc_pkg::out_t load_data_i,
  output logic          free_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wwc_pkg::out_t out_data_o
);
  import wwc_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= load_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/wah_word_combiner_core.sv]
// ----------------------------------------------------------------------------
// Word-aligned hybrid bitmap word combiner
// Builds compressed bitmap words from a stream of literal, fill and end
// descriptors, emitting each word once a later descriptor displaces it.
// ----------------------------------------------------------------------------
// Throughput: one descriptor per cycle while the output side takes its words.
// A descriptor waits in the input register until the output register is free,
// then is applied to the held word; a word that it displaces is loaded into the output register at that edge.
// Reset empties the input register, the held word and the output register.
module wah_word_combiner_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wwc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output wwc_pkg::out_t out_data_o
);
  import wwc_pkg::*;

  logic item_valid;
  in_t  item;
  logic out_free;
  logic fire;
  logic emit;
  out_t emit_data;

  assign fire = item_valid && out_free;

  wwc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .take_i     (fire),
    .valid_o    (item_valid),
    .data_o     (item)
  );

  wwc_combine u_combine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item),
    .emit_o      (emit),
    .emit_data_o (emit_data)
  );

  wwc_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .load_data_i (emit_data),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
